/* rtl/xps_pkg.sv */
// ----------------------------------------------------------------------------
// xps_pkg
// Shared types, byte codes and helpers for the x86 prefix scanner.
// ----------------------------------------------------------------------------
package xps_pkg;

  localparam logic [7:0] PFX_LOCK  = 8'hF0;
  localparam logic [7:0] PFX_REPNE = 8'hF2;
  localparam logic [7:0] PFX_REP   = 8'hF3;
  localparam logic [7:0] PFX_ES    = 8'h26;
  localparam logic [7:0] PFX_CS    = 8'h2E;
  localparam logic [7:0] PFX_SS    = 8'h36;
  localparam logic [7:0] PFX_DS    = 8'h3E;
  localparam logic [7:0] PFX_FS    = 8'h64;
  localparam logic [7:0] PFX_GS    = 8'h65;
  localparam logic [7:0] PFX_OPSZ  = 8'h66;
  localparam logic [7:0] PFX_ADSZ  = 8'h67;
  localparam logic [7:0] OP_ESCAPE = 8'h0F;

  localparam logic [3:0] COUNT_MAX = 4'hF;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_ILLEGAL    = 2'd1;
  localparam logic [1:0] STATUS_INCOMPLETE = 2'd2;

  localparam logic [1:0] REP_NONE  = 2'd0;
  localparam logic [1:0] REP_NE    = 2'd1;
  localparam logic [1:0] REP_E     = 2'd2;

  localparam logic [2:0] SEG_NONE = 3'd0;
  localparam logic [2:0] SEG_ES   = 3'd1;
  localparam logic [2:0] SEG_CS   = 3'd2;
  localparam logic [2:0] SEG_SS   = 3'd3;
  localparam logic [2:0] SEG_DS   = 3'd4;
  localparam logic [2:0] SEG_FS   = 3'd5;
  localparam logic [2:0] SEG_GS   = 3'd6;

  localparam int OUT_BITS = 24;
  localparam int ADDR_BITS = 3;
  localparam logic [0:0] REG_MODE_16BIT = 1'b0;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] prefix_count;
    logic       lock_seen;
    logic [1:0] rep_kind;
    logic [2:0] segment_override;
    logic [1:0] size_flags;
    logic [7:0] opcode_byte;
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [2:0] seg_of(input logic [7:0] b);
    logic [2:0] s;
    case (b)
      PFX_ES:  s = SEG_ES;
      PFX_CS:  s = SEG_CS;
      PFX_SS:  s = SEG_SS;
      PFX_DS:  s = SEG_DS;
      PFX_FS:  s = SEG_FS;
      PFX_GS:  s = SEG_GS;
      default: s = SEG_NONE;
    endcase
    return s;
  endfunction

endpackage

/* rtl/xps_front.sv */
// ----------------------------------------------------------------------------
// xps_front
// Classifies each accepted byte, tracks collected prefixes and pushes one
// result record per finished scan.
// ----------------------------------------------------------------------------
module xps_front (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  code_byte,
  input  logic        begin_insn,
  input  logic        last_in_buffer,
  output logic        push,
  output xps_pkg::rec_t push_rec
);
  import xps_pkg::*;

  typedef struct packed {
    logic       scanning;
    logic [3:0] count;
    logic       lock;
    logic       repne;
    logic       rep;
    logic [2:0] seg;
    logic [1:0] size;
    logic       illegal;
  } scan_t;

  scan_t scan;
  scan_t base;
  scan_t scan_next;
  logic [2:0] seg;
  logic       is_pref;
  logic       result;

  always_comb begin
    base = scan;
    if (begin_insn) begin
      base = '0;
      base.scanning = 1'b1;
    end
    scan_next = base;
    seg = seg_of(code_byte);
    is_pref = 1'b1;
    if (seg != SEG_NONE) begin
      if (base.seg != SEG_NONE) scan_next.illegal = 1'b1;
      else scan_next.seg = seg;
    end else if (code_byte == PFX_LOCK) begin
      if (base.lock) scan_next.illegal = 1'b1;
      else scan_next.lock = 1'b1;
    end else if (code_byte == PFX_REPNE) begin
      if (base.rep) scan_next.illegal = 1'b1;
      else scan_next.repne = 1'b1;
    end else if (code_byte == PFX_REP) begin
      if (base.repne) scan_next.illegal = 1'b1;
      else scan_next.rep = 1'b1;
    end else if (code_byte == PFX_OPSZ) begin
      scan_next.size[0] = 1'b1;
    end else if (code_byte == PFX_ADSZ) begin
      scan_next.size[1] = 1'b1;
    end else begin
      is_pref = 1'b0;
    end
    if (is_pref && base.count != COUNT_MAX) scan_next.count = base.count + 4'd1;
    result = base.scanning && (!is_pref || last_in_buffer);
    if (!base.scanning) scan_next = base;
    if (result) scan_next.scanning = 1'b0;

    push_rec.prefix_count     = scan_next.count;
    push_rec.lock_seen        = scan_next.lock;
    push_rec.rep_kind         = scan_next.repne ? REP_NE : (scan_next.rep ? REP_E : REP_NONE);
    push_rec.segment_override = scan_next.seg;
    push_rec.size_flags       = scan_next.size;
    push_rec.opcode_byte      = 8'd0;
    if (scan_next.illegal) begin
      push_rec.status = STATUS_ILLEGAL;
    end else if (is_pref || (code_byte == OP_ESCAPE && last_in_buffer)) begin
      push_rec.status = STATUS_INCOMPLETE;
    end else begin
      push_rec.status      = STATUS_OK;
      push_rec.opcode_byte = code_byte;
    end
  end

  assign push = accept && result;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= '0;
    end else if (accept) begin
      scan <= scan_next;
    end
  end

endmodule

/* rtl/xps_queue.sv */
// ----------------------------------------------------------------------------
// xps_queue
// Short register queue of result records between front and back.
// ----------------------------------------------------------------------------
module xps_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  xps_pkg::rec_t push_rec,
  input  logic          pop,
  output xps_pkg::rec_t head_rec,
  output xps_pkg::q_stat_t stat
);
  import xps_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  rec_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign stat.full  = (count == FULL_CNT);
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_rec   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

/* rtl/xps_back.sv */
// ----------------------------------------------------------------------------
// xps_back
// Pops result records, resolves effective sizes and holds the output register.
// ----------------------------------------------------------------------------
module xps_back (
  input  logic                          clk,
  input  logic                          rst,
  input  xps_pkg::q_stat_t              stat,
  input  xps_pkg::rec_t                 head_rec,
  input  logic                          mode_16bit,
  output logic                          pop,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [xps_pkg::OUT_BITS-1:0]  m_tdata
);
  import xps_pkg::*;

  logic operand_32;
  logic address_32;

  assign pop        = !stat.empty && (!m_tvalid || m_tready);
  assign operand_32 = mode_16bit ^ !head_rec.size_flags[0];
  assign address_32 = mode_16bit ^ !head_rec.size_flags[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {2'b00, head_rec.opcode_byte, address_32, operand_32,
                  head_rec.segment_override, head_rec.rep_kind, head_rec.lock_seen,
                  head_rec.prefix_count, head_rec.status};
    end
  end

endmodule

/* rtl/x86_prefix_scanner_unit.sv */
// ----------------------------------------------------------------------------
// x86_prefix_scanner_unit
// Legacy prefix scanner for x86 instruction bytes with an APB mode register.
// ----------------------------------------------------------------------------
// One byte is accepted every clock cycle while the result queue has room. The
// front classifies each byte in the cycle it is accepted; the result of a
// finished scan enters the queue at that edge and moves on to the output
// register once that register is empty or being taken, and is shown from there.
// The queue depth (QUEUE_DEPTH) sets how many results can wait behind a
// stalled output before s_tready drops.
module x86_prefix_scanner_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata: [7:0] code_byte
  input  logic [7:0]                     s_tdata,
  // s_tuser: [0] begin_insn
  input  logic                           s_tuser,
  input  logic                           s_tlast,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // m_tdata: [1:0] status, [5:2] prefix_count, [6] lock_seen, [8:7] rep_kind,
  //          [11:9] segment_override, [12] operand_32, [13] address_32,
  //          [21:14] opcode_byte, [23:22] zero
  output logic [xps_pkg::OUT_BITS-1:0]   m_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [xps_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import xps_pkg::*;

  logic    mode_16bit;
  logic    accept;
  logic    push;
  logic    pop;
  rec_t    push_rec;
  rec_t    head_rec;
  q_stat_t q_stat;
  logic    reg_write;
  logic    reg_hit;

  assign pready    = 1'b1;
  assign reg_hit   = (paddr[ADDR_BITS-1:2] == REG_MODE_16BIT) && (paddr[1:0] == 2'b00);
  assign reg_write = psel && penable && pwrite && pready && reg_hit;
  assign prdata    = reg_hit ? {31'd0, mode_16bit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_16bit <= 1'b0;
    end else if (reg_write) begin
      mode_16bit <= pwdata[0];
    end
  end

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  xps_front u_front (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .code_byte      (s_tdata),
    .begin_insn     (s_tuser),
    .last_in_buffer (s_tlast),
    .push           (push),
    .push_rec       (push_rec)
  );

  xps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .stat     (q_stat)
  );

  xps_back u_back (
    .clk        (clk),
    .rst        (rst),
    .stat       (q_stat),
    .head_rec   (head_rec),
    .mode_16bit (mode_16bit),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

`ifndef SYNTH
  a_drain_queue: assert property (@(posedge clk) disable iff (rst)
    (!q_stat.empty && !m_tvalid) |=> m_tvalid)
    else $error("queued result not moved to output");

  a_valid_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(m_tvalid) |-> $past(m_tready))
    else $error("output dropped without handshake");

  a_mode_write: assert property (@(posedge clk) disable iff (rst)
    reg_write |=> (mode_16bit == $past(pwdata[0])))
    else $error("mode register not updated");
`endif

endmodule
